// ===== src/tspe_pkg.sv =====
// shared types and constants for the transport stream payload extractor
// no dependencies

package tspe_pkg;

   // packet geometry
   localparam int unsigned PACKET_BYTES = 188;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned PID_W        = 13;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned PID_HI_W     = PID_W - BYTE_W;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [PID_W-1:0]  pid_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // header byte positions
   localparam pos_type POS_SYNC      = pos_type'(0);
   localparam pos_type POS_PID_HI    = pos_type'(1);
   localparam pos_type POS_PID_LO    = pos_type'(2);
   localparam pos_type POS_FLAGS     = pos_type'(3);
   localparam pos_type POS_ADAPT_LEN = pos_type'(4);
   localparam pos_type POS_LAST      = pos_type'(PACKET_BYTES - 1);
   localparam pos_type POS_NONE      = pos_type'(PACKET_BYTES);

   // payload offsets
   localparam pos_type HDR_BYTES       = pos_type'(4);
   localparam int unsigned ADAPT_BASE  = 5;

   // adaptation field control codes
   typedef enum logic [1:0] {
      AFC_RESERVED      = 2'd0,
      AFC_PAYLOAD_ONLY  = 2'd1,
      AFC_ADAPT_ONLY    = 2'd2,
      AFC_ADAPT_PAYLOAD = 2'd3
   } afc_type;

   localparam pid_type PID_RESET = pid_type'(2);

endpackage

// ===== src/tspe_req_if.sv =====
// input channel: one raw transport stream byte per transfer
// depends on tspe_pkg

interface tspe_req_if;
   import tspe_pkg::*;

   logic     valid;
   logic     ready;
   byte_type stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== src/tspe_rsp_if.sv =====
// result channel: one payload byte with its last-of-packet mark per transfer
// depends on tspe_pkg

interface tspe_rsp_if;
   import tspe_pkg::*;

   logic     valid;
   logic     ready;
   byte_type payload_byte;
   logic     last_of_packet;

   modport source (output valid, output payload_byte, output last_of_packet, input ready);
   modport sink   (input valid, input payload_byte, input last_of_packet, output ready);
endinterface

// ===== src/ts_pid_payload_extractor.sv =====
// Payload extractor for one packet identifier of an aligned 188-byte transport stream.
// Depends on tspe_pkg, tspe_req_if and tspe_rsp_if.
//
// Bytes arrive one per transfer, the first byte after reset being byte 0 of a packet; the
// sync byte is not checked. Packets whose 13-bit identifier equals target_pid (csr_wr_data,
// reset 2, sampled when byte 2 is processed) pass their payload bytes on, the packet's final
// byte marked with last_of_packet. An adaptation field reaching to or past the packet end
// leaves no payload. The block takes one byte per cycle unless the result side stalls:
// a byte is held in an input register, classified by a short position/header compare,
// and then moves on into the result register; a stalled result holds back new input
// only once the input register is full as well. There is no clearing pass after reset.

module ts_pid_payload_extractor
   import tspe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tspe_req_if.sink      req_ch,
   tspe_rsp_if.source    rsp_ch,
   input  logic          csr_wr_en,
   input  pid_type       csr_wr_data
);

   // registers
   pid_type  target_pid_ff,  target_pid_in;
   logic     s1_valid_ff,    s1_valid_in;
   byte_type s1_byte_ff,     s1_byte_in;
   pos_type  pos_ff,         pos_in;
   logic [PID_HI_W-1:0] pid_hi_ff, pid_hi_in;
   logic     pid_match_ff,   pid_match_in;
   afc_type  afc_ff,         afc_in;
   pos_type  pstart_ff,      pstart_in;
   logic     rsp_valid_ff,   rsp_valid_in;
   byte_type rsp_byte_ff,    rsp_byte_in;
   logic     rsp_last_ff,    rsp_last_in;

   logic out_free;
   logic s1_adv;
   logic req_xfer;
   logic emit;
   logic [POS_W:0] adapt_end;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign adapt_end = {1'b0, s1_byte_ff} + (POS_W+1)'(ADAPT_BASE);

   // header tracking and payload decision for the byte in the input register
   always_comb begin
      pos_in       = pos_ff;
      pid_hi_in    = pid_hi_ff;
      pid_match_in = pid_match_ff;
      afc_in       = afc_ff;
      pstart_in    = pstart_ff;
      if (s1_adv) begin
         unique case (pos_ff)
            POS_SYNC: begin
               pstart_in = POS_NONE;
            end
            POS_PID_HI: begin
               pid_hi_in = s1_byte_ff[PID_HI_W-1:0];
            end
            POS_PID_LO: begin
               pid_match_in = ({pid_hi_ff, s1_byte_ff} == target_pid_ff);
            end
            POS_FLAGS: begin
               afc_in    = afc_type'(s1_byte_ff[5:4]);
               pstart_in = (afc_type'(s1_byte_ff[5:4]) == AFC_PAYLOAD_ONLY) ? HDR_BYTES
                                                                             : POS_NONE;
            end
            POS_ADAPT_LEN: begin
               if (afc_ff == AFC_ADAPT_PAYLOAD) begin
                  pstart_in = (adapt_end > (POS_W+1)'(PACKET_BYTES)) ? POS_NONE
                                                                     : adapt_end[POS_W-1:0];
               end
            end
            default: begin
            end
         endcase
         pos_in = (pos_ff == POS_LAST) ? POS_SYNC : pos_ff + pos_type'(1);
      end
   end

   assign emit = pid_match_in && (pos_ff >= pstart_in);

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_ch.stream_byte;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = s1_adv && emit;
         rsp_byte_in  = s1_byte_ff;
         rsp_last_in  = (pos_ff == POS_LAST);
      end
   end

   // configuration register
   assign target_pid_in = csr_wr_en ? csr_wr_data : target_pid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_pid_ff <= PID_RESET;
         s1_valid_ff   <= 1'b0;
         pos_ff        <= POS_SYNC;
         pid_hi_ff     <= '0;
         pid_match_ff  <= 1'b0;
         afc_ff        <= AFC_RESERVED;
         pstart_ff     <= POS_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_pid_ff <= target_pid_in;
         s1_valid_ff   <= s1_valid_in;
         pos_ff        <= pos_in;
         pid_hi_ff     <= pid_hi_in;
         pid_match_ff  <= pid_match_in;
         afc_ff        <= afc_in;
         pstart_ff     <= pstart_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.payload_byte   = rsp_byte_ff;
   assign rsp_ch.last_of_packet = rsp_last_ff;

   // checks
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_NONE)
      else $error("byte position out of packet range");

   a_pstart_range: assert property (@(posedge clock) disable iff (reset)
      pstart_ff >= HDR_BYTES && pstart_ff <= POS_NONE)
      else $error("payload start out of range");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      s1_adv && emit |=> rsp_valid_ff)
      else $error("payload byte lost between stages");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty input register");

endmodule

// ===== test/tspe_payload_checker.sv =====
// result checker for the transport stream payload extractor: tracks packet headers,
// predicts which bytes come out and compares them with the result channel
// depends on tspe_pkg, tspe_req_if and tspe_rsp_if
`timescale 1ns / 100ps

module tspe_payload_checker
   import tspe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   tspe_req_if     req_ch,
   tspe_rsp_if     rsp_ch,
   input  logic    csr_wr_en,
   input  pid_type csr_wr_data,
   output int      fail_count,
   output int      pending,
   output int      results_checked,
   output int      bytes_seen
);

   typedef struct packed {
      byte_type payload;
      logic     last;
   } payload_item_type;

   // payload bytes still owed by the block, oldest first
   payload_item_type expected_payload [$];

   // own copy of the header tracking state
   pos_type              byte_pos;
   logic [PID_HI_W-1:0]  pid_hi;
   logic                 pid_hit;
   afc_type              afc;
   logic [8:0]           payload_from;
   pid_type              watched_pid;

   // advance the header tracker by one stream byte and queue its payload byte, if any
   function automatic void predict_byte(input byte_type b);
      logic [8:0] adapt_end;
      case (byte_pos)
         POS_SYNC: begin
            payload_from = 9'(PACKET_BYTES);
         end
         POS_PID_HI: begin
            pid_hi = b[PID_HI_W-1:0];
         end
         POS_PID_LO: begin
            pid_hit = ({pid_hi, b} == watched_pid);
         end
         POS_FLAGS: begin
            afc = afc_type'(b[5:4]);
            payload_from = (afc == AFC_PAYLOAD_ONLY) ? 9'(HDR_BYTES) : 9'(PACKET_BYTES);
         end
         POS_ADAPT_LEN: begin
            if (afc == AFC_ADAPT_PAYLOAD) begin
               // an adaptation field running to or past the end leaves no payload
               adapt_end = 9'(b) + 9'(ADAPT_BASE);
               payload_from = (adapt_end > PACKET_BYTES) ? 9'(PACKET_BYTES) : adapt_end;
            end
         end
         default: ;
      endcase
      if (pid_hit && 9'(byte_pos) >= payload_from)
         expected_payload.push_back('{payload: b, last: (byte_pos == POS_LAST)});
      byte_pos = (byte_pos == POS_LAST) ? POS_SYNC : pos_type'(byte_pos + 1'b1);
   endfunction

   task automatic report_mismatch(input string what, input payload_item_type want);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected byte %h last %b, got byte %h last %b", $time, what,
                  want.payload, want.last, rsp_ch.payload_byte, rsp_ch.last_of_packet);
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      payload_item_type want;
      if (reset) begin
         byte_pos     = POS_SYNC;
         pid_hi       = '0;
         pid_hit      = 1'b0;
         afc          = AFC_RESERVED;
         payload_from = 9'(PACKET_BYTES);
         watched_pid  = PID_RESET;
         expected_payload.delete();
      end else begin
         if (csr_wr_en)
            watched_pid = csr_wr_data;
         // result transfer against the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (expected_payload.size() == 0) begin
               report_mismatch("payload byte with nothing expected", '0);
            end else begin
               want = expected_payload.pop_front();
               if (want.payload !== rsp_ch.payload_byte || want.last !== rsp_ch.last_of_packet)
                  report_mismatch("payload mismatch", want);
            end
         end
         // input transfer
         if (req_ch.valid && req_ch.ready) begin
            bytes_seen++;
            predict_byte(req_ch.stream_byte);
         end
      end
      pending = expected_payload.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the transport stream payload extractor: builds packet streams,
// drives the byte and result channels with random gaps and gives the verdict
// depends on tspe_pkg, both channel interfaces, the block and tspe_payload_checker
`timescale 1ns / 100ps

module tb_top;
   import tspe_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int TOTAL_BYTES   = 1600;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   pid_type csr_wr_data;
   logic    idle_on;
   int      stall_left;
   int      packets_sent;
   int      fail_count;
   int      pending;
   int      results_checked;
   int      bytes_seen;
   pid_type cur_target;

   byte_type pkt_buf [PACKET_BYTES];

   tspe_req_if req_ch ();
   tspe_rsp_if rsp_ch ();

   ts_pid_payload_extractor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tspe_payload_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .bytes_seen      (bytes_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // gap length: mostly short, a few long
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= pick_gap() - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // fill pkt_buf with one packet: header fields as given, random filler elsewhere
   task automatic build_packet(input pid_type pid, input afc_type afc, input byte_type alen,
                               input logic sync_ok);
      for (int i = 0; i < PACKET_BYTES; i++)
         pkt_buf[i] = byte_type'($urandom);
      if (sync_ok)
         pkt_buf[POS_SYNC] = 8'h47;
      pkt_buf[POS_PID_HI] = {3'($urandom), pid[PID_W-1:BYTE_W]};
      pkt_buf[POS_PID_LO] = pid[BYTE_W-1:0];
      pkt_buf[POS_FLAGS]  = {2'($urandom), afc, 4'($urandom)};
      if (afc == AFC_ADAPT_ONLY || afc == AFC_ADAPT_PAYLOAD)
         pkt_buf[POS_ADAPT_LEN] = alen;
      packets_sent++;
   endtask

   // transfer pkt_buf[lo..hi], with random gaps before bytes
   task automatic send_range(input int lo, input int hi);
      int gap;
      for (int i = lo; i <= hi; i++) begin
         gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid       <= 1'b1;
         req_ch.stream_byte <= pkt_buf[i];
         @(negedge clock);
         while (!req_ch.ready) @(negedge clock);
         @(posedge clock);
      end
   endtask

   task automatic send_packet(input pid_type pid, input afc_type afc, input byte_type alen);
      build_packet(pid, afc, alen, 1'b1);
      send_range(0, PACKET_BYTES - 1);
   endtask

   // stop sending, wait for owed payload bytes, then let the pipeline empty
   task automatic drain_results();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_target(input pid_type pid);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pid;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cur_target = pid;
   endtask

   // run limit
   initial begin
      #2_000_000;
      $display("** ts_pid_payload_extractor: FAILED **");
      $finish;
   end

   initial begin
      int       phase_idx;
      int       cut;
      int       r;
      pid_type  pid;
      afc_type  afc;
      byte_type alen;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.stream_byte = '0;
      idle_on            = 1'b1;
      packets_sent       = 0;
      cur_target         = PID_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset identifier, then adaptation lengths at and past the packet end
      build_packet(PID_RESET, AFC_PAYLOAD_ONLY, 8'h00, 1'b0);
      send_range(0, PACKET_BYTES - 1);
      set_target(13'h0000);
      send_packet(13'h0000, AFC_ADAPT_PAYLOAD, 8'd182);
      send_packet(13'h0000, AFC_ADAPT_PAYLOAD, 8'd183);
      send_packet(13'h0000, AFC_ADAPT_PAYLOAD, 8'd255);

      // register writes inside a packet: before and after the identifier compare
      build_packet(13'h1fff, AFC_PAYLOAD_ONLY, 8'd0, 1'b0);
      send_range(0, 1);
      set_target(13'h1fff);
      send_range(2, PACKET_BYTES - 1);
      build_packet(13'h1fff, AFC_ADAPT_PAYLOAD, 8'd7, 1'b1);
      send_range(0, 2);
      set_target(13'h1ffe);
      send_range(3, PACKET_BYTES - 1);
      // identifier one bit off the target
      send_packet(13'h1fff, AFC_PAYLOAD_ONLY, 8'd0);

      // random packets, a couple per identifier setting, up to the stream length
      phase_idx = 0;
      while (bytes_seen < TOTAL_BYTES) begin
         case (phase_idx % 4)
            1: set_target(13'h0000);
            2: set_target(13'h1fff);
            default: set_target(pid_type'($urandom));
         endcase
         idle_on = (phase_idx % 3 != 2);
         repeat (2) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               pid = cur_target;
            else if (r < 85)
               pid = cur_target ^ (pid_type'(1) << $urandom_range(0, PID_W - 1));
            else
               pid = pid_type'($urandom);
            r = $urandom_range(0, 9);
            afc = (r == 0) ? AFC_RESERVED :
                  (r == 1) ? AFC_ADAPT_ONLY :
                  (r < 6)  ? AFC_PAYLOAD_ONLY : AFC_ADAPT_PAYLOAD;
            r = $urandom_range(0, 99);
            alen = (r < 60) ? byte_type'($urandom_range(0, 20)) :
                   (r < 75) ? byte_type'($urandom_range(0, 181)) :
                   (r < 85) ? byte_type'($urandom_range(182, 183)) :
                              byte_type'($urandom_range(184, 255));
            build_packet(pid, afc, alen, $urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) == 0) begin
               // change the identifier somewhere inside this packet
               cut = $urandom_range(1, PACKET_BYTES - 1);
               send_range(0, cut - 1);
               set_target($urandom_range(0, 1) ? pid : pid_type'($urandom));
               send_range(cut, PACKET_BYTES - 1);
            end else begin
               send_range(0, PACKET_BYTES - 1);
            end
         end
         phase_idx++;
      end

      drain_results();
      @(negedge clock);
      $display("stream of %0d bytes in %0d packets, %0d payload bytes checked",
               bytes_seen, packets_sent, results_checked);
      $display("identifiers 0, 8191 and random, writes inside packets, long adaptation fields");
      if (pending != 0)
         $display("%0d expected payload bytes never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("** ts_pid_payload_extractor: PASSED **");
      end else begin
         $display("** ts_pid_payload_extractor: FAILED **");
      end
      $finish;
   end

endmodule
